// ===== sv/ttl_kvt_pkg.sv =====
// Package for the TTL key/value table: sizes, request kinds, status codes,
// and the command/status structs shared between controller and datapath.
`default_nettype none
package ttl_kvt_pkg;
   localparam int DEPTH = 64;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int KEY_W = 64;
   localparam int VAL_W = 64;
   localparam int EXP_W = 33;
   localparam int CNT_W = 48;
   localparam int LIM_W = 7;

   localparam logic [2:0] KIND_GET    = 3'd0;
   localparam logic [2:0] KIND_SET    = 3'd1;
   localparam logic [2:0] KIND_DELETE = 3'd2;
   localparam logic [2:0] KIND_FLUSH  = 3'd3;
   localparam logic [2:0] KIND_STATUS = 3'd4;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NOTFOUND = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;

   // controller -> datapath
   typedef struct packed {
      logic             load;      // capture request
      logic             rd_en;     // read slot at idx
      logic [IDX_W-1:0] idx;
      logic             drop;      // clear active of slot idx
      logic             wr_val;    // write value+expiry at idx
      logic             wr_key;    // write key + set active at idx
      logic             flush;
      logic             count_rm;  // bump removed count
      logic             hit_inc;
      logic             miss_inc;
      logic             set_inc;
      logic             clr_rd;
   } cmd_type;

   // datapath -> controller (about slot read last cycle)
   typedef struct packed {
      logic active;
      logic key_eq;
      logic expired;
      logic free_any;   // active flag of idx is clear (combinational)
   } stat_type;
endpackage
`default_nettype wire

// ===== sv/ttl_kvt_datapath.sv =====
// Datapath of the TTL key/value table: slot memories, active flags, totals.
// Depends on ttl_kvt_pkg.
`default_nettype none
module ttl_kvt_datapath (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire ttl_kvt_pkg::cmd_type        cmd,
   input  wire logic [63:0]                 in_key,
   input  wire logic [63:0]                 in_value,
   input  wire logic [30:0]                 in_ttl,
   input  wire logic [31:0]                 in_now,
   output ttl_kvt_pkg::stat_type            stat,
   output logic [63:0]                      read_value,
   output logic [ttl_kvt_pkg::LIM_W-1:0]    entry_count,
   output logic [ttl_kvt_pkg::LIM_W-1:0]    removed,
   output logic [ttl_kvt_pkg::CNT_W-1:0]    hit_count,
   output logic [ttl_kvt_pkg::CNT_W-1:0]    miss_count,
   output logic [ttl_kvt_pkg::CNT_W-1:0]    set_count
);
   import ttl_kvt_pkg::*;

   logic [KEY_W-1:0] key_mem [DEPTH];
   logic [VAL_W-1:0] val_mem [DEPTH];
   logic [EXP_W-1:0] exp_mem [DEPTH];
   logic [DEPTH-1:0] active_ff;
   logic [KEY_W-1:0] key_ff, rkey_ff;
   logic [VAL_W-1:0] val_ff, rval_ff, rd_ff;
   logic [EXP_W-1:0] exp_ff, rexp_ff;
   logic [31:0]      now_ff;
   logic             ract_ff;
   logic [LIM_W-1:0] cnt_ff, rm_ff;
   logic [CNT_W-1:0] hit_ff, miss_ff, set_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff <= in_key;
         val_ff <= in_value;
         now_ff <= in_now;
         exp_ff <= (in_ttl != '0) ? ({1'b0, in_now} + {2'b0, in_ttl}) : '0;
      end
      if (cmd.rd_en) begin
         rkey_ff <= key_mem[cmd.idx];
         rval_ff <= val_mem[cmd.idx];
         rexp_ff <= exp_mem[cmd.idx];
      end
      if (cmd.wr_val) begin
         val_mem[cmd.idx] <= val_ff;
         exp_mem[cmd.idx] <= exp_ff;
      end
      if (cmd.wr_key) key_mem[cmd.idx] <= key_ff;
      if (cmd.clr_rd) rd_ff <= '0;
      else if (cmd.hit_inc) rd_ff <= rval_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
         ract_ff   <= 1'b0;
         cnt_ff    <= '0;
         rm_ff     <= '0;
         hit_ff    <= '0;
         miss_ff   <= '0;
         set_ff    <= '0;
      end else begin
         if (cmd.rd_en) ract_ff <= active_ff[cmd.idx];
         if (cmd.flush) begin
            active_ff <= '0;
            cnt_ff    <= '0;
         end else if (cmd.drop) begin
            active_ff[cmd.idx] <= 1'b0;
            if (cnt_ff != '0) cnt_ff <= cnt_ff - 1'b1;
         end else if (cmd.wr_key) begin
            active_ff[cmd.idx] <= 1'b1;
            cnt_ff <= cnt_ff + 1'b1;
         end
         if (cmd.load) rm_ff <= '0;
         else if (cmd.count_rm) rm_ff <= rm_ff + 1'b1;
         if (cmd.hit_inc)  hit_ff  <= hit_ff + 1'b1;
         if (cmd.miss_inc) miss_ff <= miss_ff + 1'b1;
         if (cmd.set_inc)  set_ff  <= set_ff + 1'b1;
      end
   end

   always_comb begin
      stat.active   = ract_ff;
      stat.key_eq   = (rkey_ff == key_ff);
      stat.expired  = (rexp_ff != '0) && ({1'b0, now_ff} > rexp_ff);
      stat.free_any = ~active_ff[cmd.idx];
   end

   assign read_value  = rd_ff;
   assign entry_count = cnt_ff;
   assign removed     = rm_ff;
   assign hit_count   = hit_ff;
   assign miss_count  = miss_ff;
   assign set_count   = set_ff;
endmodule
`default_nettype wire

// ===== sv/ttl_kvt_ctrl.sv =====
// Controller of the TTL key/value table: scans slots one at a time and
// sequences lookup, insert, delete, flush and sweep. Depends on ttl_kvt_pkg.
`default_nettype none
module ttl_kvt_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_fire,
   input  wire logic [2:0]                  req_kind,
   input  wire logic [ttl_kvt_pkg::LIM_W-1:0] limit,
   input  wire logic [ttl_kvt_pkg::LIM_W-1:0] entry_count,
   input  wire ttl_kvt_pkg::stat_type       stat,
   input  wire logic                        out_free,
   output ttl_kvt_pkg::cmd_type             cmd,
   output logic                             busy,
   output logic                             done,
   output logic [1:0]                       status
);
   import ttl_kvt_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_READ  = 6'b000010,
      S_CHECK = 6'b000100,
      S_FREE  = 6'b001000,
      S_SWEEP = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

   state_type        state_ff, state_in;
   logic [2:0]       kind_ff, kind_in;
   logic [LIM_W-1:0] idx_ff, idx_in, lim;
   logic [1:0]       st_ff, st_in;
   logic             last;

   assign lim  = (limit > LIM_W'(DEPTH)) ? LIM_W'(DEPTH) : limit;
   assign last = (idx_ff + 1'b1) >= lim;

   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      idx_in   = idx_ff;
      st_in    = st_ff;
      cmd      = '0;
      cmd.idx  = idx_ff[IDX_W-1:0];
      case (state_ff)
         S_IDLE: if (req_fire) begin
            cmd.load   = 1'b1;
            cmd.clr_rd = 1'b1;
            kind_in    = req_kind;
            idx_in     = '0;
            st_in      = ST_OK;
            case (req_kind)
               KIND_GET, KIND_SET, KIND_DELETE, KIND_STATUS:
                  state_in = (lim == '0) ? S_DONE : S_READ;
               KIND_FLUSH: begin
                  cmd.flush = 1'b1;
                  state_in  = S_DONE;
               end
               default: state_in = S_DONE;
            endcase
            if (lim == '0) begin
               case (req_kind)
                  KIND_GET: begin
                     st_in = ST_NOTFOUND;
                     cmd.miss_inc = 1'b1;
                  end
                  KIND_DELETE: st_in = ST_NOTFOUND;
                  KIND_SET: st_in = ST_FULL;
                  default: ;
               endcase
            end
         end
         S_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = (kind_ff == KIND_STATUS) ? S_SWEEP : S_CHECK;
         end
         S_CHECK: begin
            if (stat.active && stat.key_eq) begin
               state_in = S_DONE;
               if (stat.expired) begin
                  cmd.drop = 1'b1;
                  case (kind_ff)
                     KIND_GET: begin
                        st_in = ST_NOTFOUND;
                        cmd.miss_inc = 1'b1;
                     end
                     KIND_DELETE: st_in = ST_NOTFOUND;
                     default: begin
                        idx_in   = '0;
                        state_in = S_FREE;
                     end
                  endcase
               end else begin
                  case (kind_ff)
                     KIND_GET: cmd.hit_inc = 1'b1;
                     KIND_DELETE: cmd.drop = 1'b1;
                     default: begin
                        cmd.wr_val  = 1'b1;
                        cmd.set_inc = 1'b1;
                     end
                  endcase
               end
            end else if (last) begin
               state_in = S_DONE;
               case (kind_ff)
                  KIND_GET: begin
                     st_in = ST_NOTFOUND;
                     cmd.miss_inc = 1'b1;
                  end
                  KIND_DELETE: st_in = ST_NOTFOUND;
                  default: begin
                     idx_in   = '0;
                     state_in = S_FREE;
                  end
               endcase
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_READ;
            end
         end
         S_FREE: begin
            // insert into first free slot below the limit
            if (entry_count >= lim) begin
               st_in    = ST_FULL;
               state_in = S_DONE;
            end else if (stat.free_any) begin
               cmd.wr_val  = 1'b1;
               cmd.wr_key  = 1'b1;
               cmd.set_inc = 1'b1;
               state_in    = S_DONE;
            end else if (last) begin
               st_in    = ST_FULL;
               state_in = S_DONE;
            end else idx_in = idx_ff + 1'b1;
         end
         S_SWEEP: begin
            if (stat.active && stat.expired) begin
               cmd.drop     = 1'b1;
               cmd.count_rm = 1'b1;
            end
            if (last) state_in = S_DONE;
            else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_READ;
            end
         end
         S_DONE: if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         kind_ff  <= '0;
         idx_ff   <= '0;
         st_ff    <= ST_OK;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
         idx_ff   <= idx_in;
         st_ff    <= st_in;
      end
   end

   assign busy   = (state_ff != S_IDLE);
   assign done   = (state_ff == S_DONE) && out_free;
   assign status = st_ff;
endmodule
`default_nettype wire

// ===== sv/ttl_key_value_table_core.sv =====
// Top level of the TTL key/value table; joins controller and datapath and
// holds the result register and the slot limit. Depends on ttl_kvt_pkg.
//
// Usage:
//  - req_ channel carries one request transaction: tuser = kind,
//    tdata = {now, ttl, value, key}. One rsp_ transaction per request.
//  - csr_wr_en/csr_wr_data write the slot limit (reset 64); write only idle.
//  - For limit L (clamped to 64), get and delete read and check slots 0 up
//    to L-1 in turn, and status reads and sweeps them; a set of a new key
//    first scans, then makes an insert pass of one slot per cycle. Flush
//    and unused kinds go straight to the result. Get/delete/set stop early
//    at a matching slot.
//  - The scan over the single-ported slot memory sets the rate; one
//    request is in flight at a time, and the next can be accepted in the
//    cycle after the previous result is loaded into the output register.
//  - Result is held in an output register; while rsp_tready is low the
//    result stays and the next request may be accepted and worked on
//    up to its end, then waits.
//  - Reset clears the active flags, count and totals at once; key, value
//    and expiry memories are not cleared.
`default_nettype none
module ttl_key_value_table_core (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [191:0] req_tdata,  // key[63:0], value[127:64], ttl[158:128], now[190:159]
   input  wire logic [2:0]   req_tuser,  // kind
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [223:0]      rsp_tdata,  // status, read_value, entry_count, hit, miss, set, removed
   input  wire logic         csr_wr_en,
   input  wire logic [6:0]   csr_wr_data
);
   import ttl_kvt_pkg::*;

   cmd_type          cmd;
   stat_type         stat;
   logic             busy, done, fire, out_free;
   logic [1:0]       status;
   logic [63:0]      read_value;
   logic [LIM_W-1:0] cnt, rm, lim_ff;
   logic [CNT_W-1:0] hit, miss, set;
   logic             ovld_ff;
   logic [223:0]     odata_ff;

   assign req_tready = ~busy;
   assign fire       = req_tvalid & req_tready;
   assign out_free   = ~ovld_ff | rsp_tready;

   ttl_kvt_ctrl u_ctrl (
      .clock, .reset,
      .req_fire(fire), .req_kind(req_tuser), .limit(lim_ff),
      .entry_count(cnt), .stat, .out_free, .cmd, .busy, .done, .status
   );

   ttl_kvt_datapath u_dp (
      .clock, .reset, .cmd,
      .in_key(req_tdata[63:0]), .in_value(req_tdata[127:64]),
      .in_ttl(req_tdata[158:128]), .in_now(req_tdata[190:159]),
      .stat, .read_value, .entry_count(cnt), .removed(rm),
      .hit_count(hit), .miss_count(miss), .set_count(set)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         ovld_ff <= 1'b0;
         lim_ff  <= LIM_W'(DEPTH);
      end else begin
         if (csr_wr_en) lim_ff <= csr_wr_data;
         if (done) ovld_ff <= 1'b1;
         else if (rsp_tready) ovld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (done) odata_ff <= {rm, set, miss, hit, cnt, read_value, status};
   end

   assign rsp_tvalid = ovld_ff;
   assign rsp_tdata  = odata_ff;
endmodule
`default_nettype wire

// ===== sv/ttl_kvt_checker.sv =====
// Port-level checker for the TTL key/value table, bound to the top level.
// Depends on ttl_kvt_pkg.
`default_nettype none
module ttl_kvt_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tvalid,
   input wire logic         req_tready,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [223:0] rsp_tdata
);
   import ttl_kvt_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp changed while stalled");
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("accepted two requests back to back");
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[1:0] != 2'd3)
      else $error("bad status code");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[72:66] <= 7'(DEPTH))
      else $error("entry count above depth");
endmodule

bind ttl_key_value_table_core ttl_kvt_checker u_chk (
   .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready, .rsp_tdata
);
`default_nettype wire
